FILE: hw/rtl/sisq_pkg.sv
// Package with constants and types shared by the select sequencer files.
package sisq_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CTRL  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_ARB_FREE  = 4'd1;
  localparam logic [3:0] ST_ARB_START = 4'd2;
  localparam logic [3:0] ST_ARB_EVAL  = 4'd3;
  localparam logic [3:0] ST_SEL_START = 4'd4;
  localparam logic [3:0] ST_SEL_DELAY = 4'd5;
  localparam logic [3:0] ST_SEL_WAIT  = 4'd6;
  localparam logic [3:0] ST_SEL_DONE  = 4'd7;
  localparam logic [3:0] ST_PIO       = 4'd8;
  localparam logic [3:0] ST_PIO_OUT   = 4'd9;
  localparam logic [3:0] ST_PIO_ACK   = 4'd10;
  localparam logic [3:0] ST_PARKED    = 4'd11;

  localparam logic [8:0] C_IO  = 9'h001;
  localparam logic [8:0] C_ATN = 9'h008;
  localparam logic [8:0] C_REQ = 9'h010;
  localparam logic [8:0] C_ACK = 9'h020;
  localparam logic [8:0] C_RST = 9'h040;
  localparam logic [8:0] C_SEL = 9'h080;
  localparam logic [8:0] C_BSY = 9'h100;

  localparam logic [4:0] REG_OWN_ID = 5'd4;
  localparam logic [4:0] REG_TGT_ID = 5'd5;
  localparam logic [4:0] REG_PIO    = 5'd8;
  localparam logic [4:0] REG_CSTAT  = 5'd18;
  localparam logic [4:0] REG_DSTAT  = 5'd19;
  localparam logic [4:0] REG_COMM   = 5'd20;

  localparam logic [15:0] CMD_CHIP_RESET = 16'h0080;
  localparam logic [15:0] CMD_DISCON     = 16'h0100;
  localparam logic [15:0] CMD_SELECT     = 16'h0400;
  localparam logic [15:0] CMD_XFER       = 16'h0800;

  localparam logic [2:0] CFG_ARB_WAIT  = 3'd0;
  localparam logic [2:0] CFG_BUS_FREE  = 3'd1;
  localparam logic [2:0] CFG_CLR_SET   = 3'd2;
  localparam logic [2:0] CFG_SETTLE    = 3'd3;
  localparam logic [2:0] CFG_SKEW_PAIR = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  reg_index;
    logic [15:0] write_data;
    logic [8:0]  bus_ctrl;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  drive_data;
    logic [8:0]  drive_ctrl;
    logic        irq;
  } out_item_t;

  // Status registers and irq, passed to the status update helpers.
  typedef struct packed {
    logic [15:0] cstat;
    logic [15:0] dstat;
    logic        irq;
  } stat_t;

  function automatic stat_t put_cstat(stat_t s, logic [15:0] v, logic [15:0] m);
    stat_t r;
    r = s;
    r.cstat = (s.cstat & ~m) | (v & m);
    if ((r.cstat & 16'h3b80) != 16'h0) begin
      r.cstat = r.cstat | 16'h8000;
      r.dstat = r.dstat | 16'h8000;
    end else begin
      r.cstat = r.cstat & ~16'h8000;
      r.dstat = r.dstat & ~16'h8000;
    end
    r.irq = (r.cstat & 16'hc000) != 16'h0;
    return r;
  endfunction

  function automatic stat_t put_dstat(stat_t s, logic [15:0] v, logic [15:0] m);
    stat_t r;
    r = s;
    r.dstat = (s.dstat & ~m) | (v & m);
    if ((r.dstat & 16'h2c10) != 16'h0) begin
      r.dstat = r.dstat | 16'h4000;
      r.cstat = r.cstat | 16'h4000;
    end else begin
      r.dstat = r.dstat & ~16'h4000;
      r.cstat = r.cstat & ~16'h4000;
    end
    r.irq = (r.dstat & 16'hc000) != 16'h0;
    return r;
  endfunction

endpackage

FILE: hw/rtl/sisq_if.sv
// Valid/ready channel interface carrying one item.
interface sisq_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sisq_core.sv
// Next-state logic for the register file and the select sequencer.
module sisq_core import sisq_pkg::*; #(
  parameter int WCB = 12
) (
  input  in_item_t       item,
  input  logic [11:0]    arb_wait,
  input  logic [11:0]    bus_free,
  input  logic [11:0]    clr_settle,
  input  logic [11:0]    settle,
  input  logic [11:0]    skew_pair,
  input  logic [3:0]     state_q,
  input  logic [WCB-1:0] wait_q,
  input  logic           armed_q,
  input  stat_t          stat_q,
  input  logic [15:0]    comm_q,
  input  logic [15:0]    own_q,
  input  logic [2:0]     tid_q,
  input  logic [7:0]     pio_q,
  input  logic [8:0]     prev_q,
  input  logic [7:0]     ddata_q,
  input  logic [8:0]     dctrl_q,
  input  logic [15:0]    misc_rd,
  input  logic           misc_hit,
  output logic [3:0]     state_d,
  output logic [WCB-1:0] wait_d,
  output logic           armed_d,
  output stat_t          stat_d,
  output logic [15:0]    comm_d,
  output logic [15:0]    own_d,
  output logic [2:0]     tid_d,
  output logic [7:0]     pio_d,
  output logic [8:0]     prev_d,
  output logic [7:0]     ddata_d,
  output logic [8:0]     dctrl_d,
  output logic [15:0]    rd_d
);

  localparam logic [WCB-1:0] WMAX = {WCB{1'b1}};

  logic [7:0]     oid, tid;
  logic [11:0]    dly;
  logic [WCB-1:0] wdec, dsat;
  logic [8:0]     c;
  logic [15:0]    wd;

  always_comb begin
    c    = item.bus_ctrl;
    wd   = item.write_data;
    oid  = 8'(1) << own_q[2:0];
    tid  = 8'(1) << tid_q;
    state_d = state_q; wait_d = wait_q; armed_d = armed_q; stat_d = stat_q;
    comm_d = comm_q; own_d = own_q; tid_d = tid_q; pio_d = pio_q; prev_d = prev_q;
    ddata_d = ddata_q; dctrl_d = dctrl_q; rd_d = 16'h0; dly = 12'h0;
    wdec = wait_q; dsat = '0;
    unique case (item.action)
      ACT_WRITE: begin
        if (item.reg_index == REG_OWN_ID) own_d = wd & 16'h8007;
        else if (item.reg_index == REG_TGT_ID) tid_d = wd[2:0];
        else if (item.reg_index == REG_PIO) pio_d = wd[7:0];
        else if (item.reg_index == REG_CSTAT) begin
          stat_d.cstat = (stat_q.cstat & ~(wd & 16'h3b88) & ~16'h0400) | (wd & 16'h0400);
          stat_d = put_cstat(stat_d, 16'h0, 16'h0);
        end else if (item.reg_index == REG_DSTAT) begin
          stat_d.dstat = stat_q.dstat & ~(wd & 16'h2008);
          stat_d = put_dstat(stat_d, 16'h0, 16'h0);
        end else if (item.reg_index == REG_COMM) begin
          comm_d = wd & 16'h9fff;
          stat_d = put_dstat(stat_d, (c[2:0] == comm_d[2:0]) ? 16'h0 : 16'h0010, 16'h0010);
          if ((wd & 16'h0f80) == CMD_CHIP_RESET) begin
            state_d = ST_IDLE; armed_d = 1'b0; wait_d = '0; ddata_d = '0;
            dctrl_d = '0; prev_d = '0; stat_d.irq = 1'b0;
          end else if ((wd & 16'h0f80) == CMD_DISCON) begin
            stat_d = put_cstat(stat_d, 16'h0, 16'h0046);
            ddata_d = '0; dctrl_d = dctrl_q & ~(C_ATN | C_SEL | C_BSY);
          end else if ((wd & 16'h0f80) == CMD_SELECT) begin
            state_d = ST_ARB_FREE; armed_d = 1'b1; wait_d = '0;
          end else if ((wd & 16'h0f80) == CMD_XFER) begin
            wait_d = '0;
            if (comm_d[15]) begin state_d = ST_PARKED; armed_d = 1'b0; end
            else begin state_d = ST_PIO; armed_d = 1'b1; end
          end
        end
      end
      ACT_READ: begin
        if (misc_hit) rd_d = misc_rd;
        else if (item.reg_index == REG_OWN_ID) rd_d = own_q;
        else if (item.reg_index == REG_TGT_ID) rd_d = {13'h0, tid_q};
        else if (item.reg_index == REG_PIO) rd_d = {8'h0, pio_q};
        else if (item.reg_index == REG_CSTAT) rd_d = stat_q.cstat;
        else if (item.reg_index == REG_DSTAT) rd_d = stat_q.dstat | {13'h0, c[2:0]};
        else if (item.reg_index == REG_COMM) rd_d = comm_q;
      end
      ACT_CTRL: begin
        if ((c & C_RST) != 9'h0) begin
          state_d = ST_IDLE; armed_d = 1'b0; wait_d = '0; ddata_d = '0;
          dctrl_d = '0; stat_d.irq = 1'b1;
        end else if (!stat_q.cstat[4] && (prev_q & C_BSY) != 9'h0 && (c & C_BSY) == 9'h0)
        begin
          state_d = ST_IDLE; armed_d = 1'b0; wait_d = '0; ddata_d = '0; dctrl_d = '0;
        end else if ((prev_q & C_REQ) == 9'h0 && (c & C_REQ) != 9'h0) begin
          if (c[2:0] == comm_q[2:0]) begin
            if (!comm_q[15]) stat_d = put_dstat(stat_q, 16'h0800, 16'h0800);
          end else begin
            state_d = ST_IDLE; armed_d = 1'b0; wait_d = '0;
            if (c[0]) stat_d = put_dstat(stat_q, 16'h0810, 16'h0810);
            else stat_d = put_dstat(stat_q, 16'h0010, 16'h0010);
          end
        end
        prev_d = c;
      end
      default: begin
        if (armed_q) begin
          if (wait_q != '0) wdec = wait_q - 1'b1;
          wait_d = wdec;
          if (wdec == '0) begin
            unique case (state_q)
              ST_ARB_FREE: if ((c & (C_SEL | C_BSY | C_RST)) == 9'h0) begin
                state_d = ST_ARB_START; dly = bus_free;
              end
              ST_ARB_START: begin
                state_d = ST_ARB_EVAL; dly = arb_wait; ddata_d = oid;
                dctrl_d = dctrl_q | C_BSY;
              end
              ST_ARB_EVAL: begin
                if ((c & C_SEL) != 9'h0 ||
                    (item.bus_data & ~((oid - 8'd1) | oid)) != 8'h0) begin
                  stat_d = put_cstat(stat_q, 16'h0002, 16'h0002);
                  state_d = ST_ARB_FREE; dly = bus_free; ddata_d = '0;
                  dctrl_d = dctrl_q & ~C_BSY;
                end else begin
                  stat_d = put_cstat(stat_q, 16'h0004, 16'h0006);
                  state_d = ST_SEL_START; dly = clr_settle;
                end
              end
              ST_SEL_START: begin
                state_d = ST_SEL_DELAY; dly = skew_pair; ddata_d = oid | tid;
                dctrl_d = dctrl_q | C_SEL;
              end
              ST_SEL_DELAY: begin
                state_d = ST_SEL_WAIT; dly = settle;
                if (comm_q[3]) dctrl_d = (dctrl_q & ~C_BSY) | C_ATN;
                else dctrl_d = dctrl_q & ~C_BSY;
              end
              ST_SEL_WAIT: begin
                if ((c & C_BSY) != 9'h0) begin state_d = ST_SEL_DONE; dly = skew_pair; end
                else state_d = ST_IDLE;
              end
              ST_SEL_DONE: begin
                state_d = ST_IDLE; stat_d = put_cstat(stat_q, 16'h00c0, 16'h00c4);
                ddata_d = '0; dctrl_d = dctrl_q & ~C_SEL;
              end
              ST_PIO: begin
                stat_d = put_dstat(stat_q, 16'h0, 16'h0800);
                if ((c & C_REQ) != 9'h0) state_d = c[0] ? ST_PARKED : ST_PIO_OUT;
              end
              ST_PIO_OUT: begin
                state_d = ST_PIO_ACK; ddata_d = pio_q; dctrl_d = dctrl_q | C_ACK;
              end
              ST_PIO_ACK: if ((c & C_REQ) == 9'h0) begin
                state_d = ST_IDLE; stat_d = put_dstat(stat_q, 16'h2000, 16'h2000);
                ddata_d = '0; dctrl_d = dctrl_q & ~C_ACK;
              end
              default: ;
            endcase
            if (WCB >= 12) dsat = WCB'(dly);
            else if ((dly >> WCB) != 12'h0) dsat = WMAX;
            else dsat = WCB'(dly);
            if (state_d == ST_IDLE || state_d == ST_PARKED) begin
              armed_d = 1'b0; wait_d = '0;
            end else wait_d = dsat;
          end
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/scsi_initiator_select_sequencer.sv
// Top level: SCSI initiator register block with arbitration/selection sequencer.
// An accepted item is registered in the input register, and its result item in the
// result register. Throughput: one item per cycle while the output is not stalled.
// A stalled result with an item in the input register holds input off for that cycle.
// Reset (rst_n low, synchronous) clears state and valid bits, loads timing defaults.
module scsi_initiator_select_sequencer import sisq_pkg::*; #(
  parameter int WAIT_COUNTER_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  sisq_if.sink        in_ch,
  sisq_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int WCB = WAIT_COUNTER_BITS;

  logic [11:0] arb_wait_r, bus_free_r, clr_settle_r, settle_r, skew_pair_r;
  logic [3:0]  state_r, state_nxt;
  logic [WCB-1:0] wait_r, wait_nxt;
  logic armed_r, armed_nxt;
  stat_t stat_r, stat_nxt;
  logic [15:0] comm_r, comm_nxt, own_r, own_nxt, rd_nxt;
  logic [2:0]  tid_r, tid_nxt;
  logic [7:0]  pio_r, pio_nxt, ddata_r, ddata_nxt;
  logic [8:0]  prev_r, prev_nxt, dctrl_r, dctrl_nxt;
  // The misc registers: written and read at a single item-chosen slot.
  logic [15:0] misc_r [11];
  logic [15:0] misc_mask, misc_rd;
  logic [3:0]  misc_slot;
  logic        misc_hit;

  // Input register stage.
  in_item_t in_r;
  logic     in_vld_r;
  // Result register plus one skid entry.
  out_item_t out_r, skid_r, res;
  logic      out_vld_r, skid_vld_r;
  logic      adv;

  // Items enter while the skid entry is free, unless the item in the input
  // register is about to take the skid because the result register stalls.
  assign in_ch.ready = !skid_vld_r && !(in_vld_r && out_vld_r && !out_ch.ready);
  assign adv = in_vld_r;

  always_comb begin
    misc_hit = 1'b1; misc_slot = 4'd0; misc_mask = 16'h0;
    unique case (in_r.reg_index)
      5'd0:  begin misc_slot = 4'd0;  misc_mask = 16'h01ff; end
      5'd1:  begin misc_slot = 4'd1;  misc_mask = 16'h01ff; end
      5'd2:  begin misc_slot = 4'd2;  misc_mask = 16'h000f; end
      5'd3:  begin misc_slot = 4'd3;  misc_mask = 16'h001f; end
      5'd6:  begin misc_slot = 4'd4;  misc_mask = 16'h0000; end
      5'd9:  begin misc_slot = 4'd5;  misc_mask = 16'h0003; end
      5'd10: begin misc_slot = 4'd6;  misc_mask = 16'h1fff; end
      5'd11: begin misc_slot = 4'd7;  misc_mask = 16'hffff; end
      5'd12: begin misc_slot = 4'd8;  misc_mask = 16'h0003; end
      5'd13: begin misc_slot = 4'd9;  misc_mask = 16'h00ff; end
      5'd21: begin misc_slot = 4'd10; misc_mask = 16'h000f; end
      default: misc_hit = 1'b0;
    endcase
    misc_rd = misc_r[misc_slot];
  end

  sisq_core #(.WCB(WCB)) u_core (
    .item(in_r), .arb_wait(arb_wait_r), .bus_free(bus_free_r),
    .clr_settle(clr_settle_r), .settle(settle_r), .skew_pair(skew_pair_r),
    .state_q(state_r), .wait_q(wait_r), .armed_q(armed_r), .stat_q(stat_r),
    .comm_q(comm_r), .own_q(own_r), .tid_q(tid_r), .pio_q(pio_r), .prev_q(prev_r),
    .ddata_q(ddata_r), .dctrl_q(dctrl_r), .misc_rd(misc_rd), .misc_hit(misc_hit),
    .state_d(state_nxt), .wait_d(wait_nxt), .armed_d(armed_nxt), .stat_d(stat_nxt),
    .comm_d(comm_nxt), .own_d(own_nxt), .tid_d(tid_nxt), .pio_d(pio_nxt),
    .prev_d(prev_nxt), .ddata_d(ddata_nxt), .dctrl_d(dctrl_nxt), .rd_d(rd_nxt)
  );

  assign res = '{read_data: rd_nxt, drive_data: ddata_nxt, drive_ctrl: dctrl_nxt,
                 irq: stat_nxt.irq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 11; i++) misc_r[i] <= '0;
    end else if (adv && misc_hit && in_r.action == ACT_WRITE) begin
      misc_r[misc_slot] <= in_r.write_data & misc_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arb_wait_r <= 12'd240; bus_free_r <= 12'd80; clr_settle_r <= 12'd120;
      settle_r <= 12'd40; skew_pair_r <= 12'd2;
      state_r <= ST_IDLE; wait_r <= '0; armed_r <= 1'b0; stat_r <= '0;
      comm_r <= '0; own_r <= '0; tid_r <= '0; pio_r <= '0; prev_r <= '0;
      ddata_r <= '0; dctrl_r <= '0;
      in_vld_r <= 1'b0; out_vld_r <= 1'b0; skid_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ARB_WAIT:  arb_wait_r <= cfg_wdata;
          CFG_BUS_FREE:  bus_free_r <= cfg_wdata;
          CFG_CLR_SET:   clr_settle_r <= cfg_wdata;
          CFG_SETTLE:    settle_r <= cfg_wdata;
          CFG_SKEW_PAIR: skew_pair_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (adv) begin
        state_r <= state_nxt; wait_r <= wait_nxt; armed_r <= armed_nxt;
        stat_r <= stat_nxt; comm_r <= comm_nxt; own_r <= own_nxt; tid_r <= tid_nxt;
        pio_r <= pio_nxt; prev_r <= prev_nxt; ddata_r <= ddata_nxt; dctrl_r <= dctrl_nxt;
      end
      in_vld_r <= in_ch.valid && in_ch.ready;
      // Output side: result register, with the skid entry behind it.
      if (!out_vld_r || out_ch.ready) begin
        if (skid_vld_r) begin
          out_vld_r <= 1'b1; skid_vld_r <= adv;
        end else begin
          out_vld_r <= adv;
        end
      end else if (adv) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_r <= in_ch.data;
    if (!out_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
        if (adv) skid_r <= res;
      end else if (adv) begin
        out_r <= res;
      end
    end else if (adv) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  // A stalled result register with a full skid entry must block input.
  a_skid_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !in_ch.ready) else $error("input open while skid full");
  // The skid fills only behind a valid stalled result.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r) else $error("skid valid without result");
  // The sequencer never counts while disarmed.
  a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> wait_r == '0) else $error("wait count nonzero while disarmed");

endmodule

FILE: verif/sisq_checker.sv
// Checker for the select sequencer: predicts each result item and compares it.
`timescale 1ns / 100ps
module sisq_checker import sisq_pkg::*; #(
  parameter int WAIT_COUNTER_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  logic [11:0] t_arb, t_free, t_clr, t_settle, t_skew;
  logic [3:0]  sq_state;
  logic [11:0] sq_wait;
  logic        sq_armed;
  logic [15:0] cstat, dstat, comm, own_id;
  logic [2:0]  tgt_id;
  logic [7:0]  pio_byte;
  logic [15:0] misc [12];
  logic [8:0]  last_ctrl;
  logic        irq_q;
  logic [7:0]  drv_data;
  logic [8:0]  drv_ctrl;
  out_item_t   expected_results [$];

  assign pending = expected_results.size();

  // Status updates are written here again rather than borrowed from the package.
  function automatic void set_conn(logic [15:0] v, logic [15:0] m);
    cstat = (cstat & ~m) | (v & m);
    if ((cstat & 16'h3b80) != 0) begin
      cstat |= 16'h8000; dstat |= 16'h8000;
    end else begin
      cstat &= ~16'h8000; dstat &= ~16'h8000;
    end
    irq_q = (cstat & 16'hc000) != 0;
  endfunction

  function automatic void set_xfer(logic [15:0] v, logic [15:0] m);
    dstat = (dstat & ~m) | (v & m);
    if ((dstat & 16'h2c10) != 0) begin
      dstat |= 16'h4000; cstat |= 16'h4000;
    end else begin
      dstat &= ~16'h4000; cstat &= ~16'h4000;
    end
    irq_q = (dstat & 16'hc000) != 0;
  endfunction

  function automatic void set_drive(logic [8:0] v, logic [8:0] m);
    drv_ctrl = (drv_ctrl & ~m) | (v & m);
  endfunction

  function automatic void halt_all();
    sq_state = ST_IDLE; sq_armed = 0; sq_wait = 0;
    drv_data = 0; drv_ctrl = 0; last_ctrl = 0; irq_q = 0;
  endfunction

  function automatic int misc_slot(logic [4:0] idx, output logic [15:0] mask);
    mask = 0;
    case (idx)
      5'd0: begin mask = 16'h1ff; return 0; end
      5'd1: begin mask = 16'h1ff; return 1; end
      5'd2: begin mask = 16'hf; return 2; end
      5'd3: begin mask = 16'h1f; return 3; end
      5'd6: return 4;
      5'd9: begin mask = 16'h3; return 5; end
      5'd10: begin mask = 16'h1fff; return 6; end
      5'd11: begin mask = 16'hffff; return 7; end
      5'd12: begin mask = 16'h3; return 8; end
      5'd13: begin mask = 16'hff; return 9; end
      5'd21: begin mask = 16'hf; return 10; end
      default: return -1;
    endcase
  endfunction

  // One sequencer step; returns the delay to the next step.
  function automatic logic [11:0] run_step(logic [8:0] ctrl, logic [7:0] bdat);
    logic [7:0]  oid, tid;
    logic [11:0] d;
    oid = 8'd1 << own_id[2:0];
    tid = 8'd1 << tgt_id;
    d = 0;
    case (sq_state)
      ST_ARB_FREE: begin
        if ((ctrl & (C_SEL | C_BSY | C_RST)) == 0) begin
          sq_state = ST_ARB_START; d = t_free;
        end
      end
      ST_ARB_START: begin
        sq_state = ST_ARB_EVAL; d = t_arb;
        drv_data = oid; set_drive(C_BSY, C_BSY);
      end
      ST_ARB_EVAL: begin
        // Lost arbitration when select is seen or a higher ID is on the bus.
        if ((ctrl & C_SEL) != 0 || (bdat & ~((oid - 8'd1) | oid)) != 0) begin
          set_conn(16'h0002, 16'h0002);
          sq_state = ST_ARB_FREE; d = t_free;
          drv_data = 0; set_drive(0, C_BSY);
        end else begin
          set_conn(16'h0004, 16'h0006);
          sq_state = ST_SEL_START; d = t_clr;
        end
      end
      ST_SEL_START: begin
        sq_state = ST_SEL_DELAY; d = t_skew;
        drv_data = oid | tid; set_drive(C_SEL, C_SEL);
      end
      ST_SEL_DELAY: begin
        sq_state = ST_SEL_WAIT; d = t_settle;
        if (comm[3]) set_drive(C_ATN, C_BSY | C_ATN);
        else set_drive(0, C_BSY);
      end
      ST_SEL_WAIT: begin
        if ((ctrl & C_BSY) != 0) begin
          sq_state = ST_SEL_DONE; d = t_skew;
        end else sq_state = ST_IDLE;
      end
      ST_SEL_DONE: begin
        sq_state = ST_IDLE;
        set_conn(16'h00c0, 16'h00c4);
        drv_data = 0; set_drive(0, C_SEL);
      end
      ST_PIO: begin
        set_xfer(0, 16'h0800);
        if ((ctrl & C_REQ) != 0) sq_state = ((ctrl & C_IO) != 0) ? ST_PARKED : ST_PIO_OUT;
      end
      ST_PIO_OUT: begin
        sq_state = ST_PIO_ACK;
        drv_data = pio_byte; set_drive(C_ACK, C_ACK);
      end
      ST_PIO_ACK: begin
        if ((ctrl & C_REQ) == 0) begin
          sq_state = ST_IDLE;
          set_xfer(16'h2000, 16'h2000);
          drv_data = 0; set_drive(0, C_ACK);
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic void write_command(logic [15:0] v, logic [8:0] ctrl);
    comm = v & 16'h9fff;
    set_xfer((ctrl[2:0] == comm[2:0]) ? 16'h0 : 16'h0010, 16'h0010);
    case (v & 16'h0f80)
      CMD_CHIP_RESET: halt_all();
      CMD_DISCON: begin
        set_conn(0, 16'h0046);
        drv_data = 0; set_drive(0, C_ATN | C_SEL | C_BSY);
      end
      CMD_SELECT: begin
        sq_state = ST_ARB_FREE; sq_armed = 1; sq_wait = 0;
      end
      CMD_XFER: begin
        sq_wait = 0;
        if (comm[15]) begin
          sq_state = ST_PARKED; sq_armed = 0;
        end else begin
          sq_state = ST_PIO; sq_armed = 1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void line_change(logic [8:0] ctrl);
    if ((ctrl & C_RST) != 0) begin
      halt_all();
      irq_q = 1;
    end else if (!cstat[4] && (last_ctrl & C_BSY) != 0 && (ctrl & C_BSY) == 0) begin
      sq_state = ST_IDLE; sq_armed = 0; sq_wait = 0;
      drv_data = 0; drv_ctrl = 0;
    end else if ((last_ctrl & C_REQ) == 0 && (ctrl & C_REQ) != 0) begin
      if (ctrl[2:0] == comm[2:0]) begin
        if (!comm[15]) set_xfer(16'h0800, 16'h0800);
      end else begin
        sq_state = ST_IDLE; sq_armed = 0; sq_wait = 0;
        if ((ctrl & C_IO) != 0) set_xfer(16'h0810, 16'h0810);
        else set_xfer(16'h0010, 16'h0010);
      end
    end
    last_ctrl = ctrl;
  endfunction

  function automatic out_item_t predict_item(in_item_t it);
    out_item_t   r;
    logic [15:0] mask, rd;
    logic [11:0] d;
    int          slot;
    rd = 0;
    slot = misc_slot(it.reg_index, mask);
    case (it.action)
      ACT_WRITE: begin
        if (slot >= 0) misc[slot] = it.write_data & mask;
        else if (it.reg_index == REG_OWN_ID) own_id = it.write_data & 16'h8007;
        else if (it.reg_index == REG_TGT_ID) tgt_id = it.write_data[2:0];
        else if (it.reg_index == REG_PIO) pio_byte = it.write_data[7:0];
        else if (it.reg_index == REG_CSTAT) begin
          cstat = (cstat & ~(it.write_data & 16'h3b88) & ~16'h0400)
                  | (it.write_data & 16'h0400);
          set_conn(0, 0);
        end else if (it.reg_index == REG_DSTAT) begin
          dstat &= ~(it.write_data & 16'h2008);
          set_xfer(0, 0);
        end else if (it.reg_index == REG_COMM) write_command(it.write_data, it.bus_ctrl);
      end
      ACT_READ: begin
        if (slot >= 0) rd = misc[slot];
        else if (it.reg_index == REG_OWN_ID) rd = own_id;
        else if (it.reg_index == REG_TGT_ID) rd = {13'd0, tgt_id};
        else if (it.reg_index == REG_PIO) rd = {8'd0, pio_byte};
        else if (it.reg_index == REG_CSTAT) rd = cstat;
        else if (it.reg_index == REG_DSTAT) rd = dstat | {13'd0, it.bus_ctrl[2:0]};
        else if (it.reg_index == REG_COMM) rd = comm;
      end
      ACT_CTRL: line_change(it.bus_ctrl);
      default: begin
        if (sq_armed) begin
          if (sq_wait != 0) sq_wait--;
          if (sq_wait == 0) begin
            d = run_step(it.bus_ctrl, it.bus_data);
            if (sq_state == ST_IDLE || sq_state == ST_PARKED) begin
              sq_armed = 0; sq_wait = 0;
            end else if (WAIT_COUNTER_BITS < 12 && (d >> WAIT_COUNTER_BITS) != 0) begin
              // The wait counter saturates at its width.
              sq_wait = 12'((1 << WAIT_COUNTER_BITS) - 1);
            end else sq_wait = d;
          end
        end
      end
    endcase
    r.read_data = rd;
    r.drive_data = drv_data;
    r.drive_ctrl = drv_ctrl;
    r.irq = irq_q;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst_n) begin
      t_arb = 12'd240; t_free = 12'd80; t_clr = 12'd120; t_settle = 12'd40; t_skew = 12'd2;
      cstat = 0; dstat = 0; comm = 0; own_id = 0; tgt_id = 0; pio_byte = 0;
      foreach (misc[i]) misc[i] = 0;
      halt_all();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: %h", got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data expected %h got %h", want.read_data, got.read_data);
            fail_count++;
          end
          if (got.drive_data !== want.drive_data) begin
            $error("drive_data expected %h got %h", want.drive_data, got.drive_data);
            fail_count++;
          end
          if (got.drive_ctrl !== want.drive_ctrl) begin
            $error("drive_ctrl expected %h got %h", want.drive_ctrl, got.drive_ctrl);
            fail_count++;
          end
          if (got.irq !== want.irq) begin
            $error("irq expected %b got %b", want.irq, got.irq);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_item(in_data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_ARB_WAIT:  t_arb = cfg_wdata;
          CFG_BUS_FREE:  t_free = cfg_wdata;
          CFG_CLR_SET:   t_clr = cfg_wdata;
          CFG_SETTLE:    t_settle = cfg_wdata;
          CFG_SKEW_PAIR: t_skew = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: verif/tb.sv
// Testbench top: drives stimulus into the select sequencer and gives the verdict.
`timescale 1ns / 100ps
module tb;
  import sisq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          quiet_cycles;
  logic        stall_pattern_on;

  sisq_if #(.W($bits(in_item_t)))  in_ch ();
  sisq_if #(.W($bits(out_item_t))) out_ch ();

  scsi_initiator_select_sequencer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // The checker sees both channels and the configuration port at the same edge as the block.
  sisq_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver stall pattern: alternates between stretches with no stalls and
  // stretches where ready drops at random.
  initial begin
    int left;
    out_ch.ready = 0;
    stall_pattern_on = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        stall_pattern_on = ~stall_pattern_on;
        left = $urandom_range(5, 60);
      end
      left--;
      out_ch.ready <= stall_pattern_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // The watchdog counts cycles with no accepted item on either side and no timing write.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  int burst_left = 0;

  // Sends one item. The sender works in bursts; between bursts it leaves a
  // random gap with valid low. Valid stays high between items of a burst.
  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] act, logic [4:0] idx, logic [15:0] wd,
                             logic [8:0] ctrl, logic [7:0] bdat);
    in_item_t it;
    it.action = act; it.reg_index = idx; it.write_data = wd;
    it.bus_ctrl = ctrl; it.bus_data = bdat;
    send_item(it);
  endtask

  // Lets all results drain before touching the timing registers.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_timing(logic [2:0] idx, logic [11:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Tick with the given bus lines; index and write data are random.
  task automatic tick(logic [8:0] ctrl, logic [7:0] bdat);
    send_fields(ACT_TICK, 5'($urandom_range(0, 31)), 16'($urandom), ctrl, bdat);
  endtask

  function automatic logic [4:0] any_index();
    return 5'(($urandom_range(0, 9) == 0) ? $urandom_range(22, 31) : $urandom_range(0, 21));
  endfunction

  // One selection attempt: program IDs, issue select, then tick through
  // arbitration and selection while a target sometimes answers with busy.
  task automatic selection_run(logic [11:0] ticks);
    logic [15:0] cmd;
    logic [7:0]  bdat;
    logic [8:0]  ctrl;
    send_fields(ACT_WRITE, REG_OWN_ID, 16'($urandom), 9'h0, 8'h0);
    send_fields(ACT_WRITE, REG_TGT_ID, 16'($urandom), 9'h0, 8'h0);
    cmd = CMD_SELECT | (16'($urandom) & 16'h800f);
    send_fields(ACT_WRITE, REG_COMM, cmd, 9'($urandom_range(0, 7)), 8'h0);
    for (int i = 0; i < ticks; i++) begin
      ctrl = ($urandom_range(0, 3) == 0) ? C_BSY : 9'h0;
      if ($urandom_range(0, 40) == 0) ctrl |= C_SEL;
      bdat = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h0;
      tick(ctrl, bdat);
    end
    send_fields(ACT_READ, REG_CSTAT, 0, 9'h0, 8'h0);
  endtask

  // PIO transfer in a random phase: transfer command, REQ edge in the matching phase,
  // ticks while REQ is held, then REQ drops so ACK is released; input phases and DMA mode park instead.
  task automatic pio_run();
    logic [15:0] cmd;
    logic [2:0]  ph;
    ph = 3'($urandom_range(0, 7));
    send_fields(ACT_WRITE, REG_PIO, 16'($urandom), 9'h0, 8'h0);
    send_fields(ACT_CTRL, 0, 0, {6'd0, ph}, 8'h0);
    cmd = CMD_XFER | {($urandom_range(0, 5) == 0), 12'd0, ph};
    send_fields(ACT_WRITE, REG_COMM, cmd, {6'd0, ph}, 8'h0);
    send_fields(ACT_CTRL, 0, 0, C_REQ | {6'd0, ph}, 8'h0);
    repeat ($urandom_range(1, 4)) tick(C_REQ | {6'd0, ph}, 8'($urandom));
    send_fields(ACT_CTRL, 0, 0, {6'd0, ph}, 8'h0);
    repeat ($urandom_range(1, 3)) tick({6'd0, ph}, 8'($urandom));
    send_fields(ACT_READ, REG_DSTAT, 0, {6'd0, ph}, 8'h0);
    send_fields(ACT_WRITE, REG_DSTAT, 16'hffff, 9'h0, 8'h0);
  endtask

  task automatic random_item();
    logic [1:0] act;
    act = 2'($urandom_range(0, 3));
    send_fields(act, any_index(), 16'($urandom), 9'($urandom), 8'($urandom));
  endtask

  initial begin
    int sent;
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short timings so that sequences finish within a few ticks.
    write_timing(CFG_ARB_WAIT, 12'd0);
    write_timing(CFG_BUS_FREE, 12'd1);
    write_timing(CFG_CLR_SET, 12'd2);
    write_timing(CFG_SETTLE, 12'd0);
    write_timing(CFG_SKEW_PAIR, 12'd1);

    // Directed: register extremes, status clears, chip reset, disconnect,
    // bus reset, phase mismatch, PIO input park and DMA park.
    send_fields(ACT_WRITE, 5'd0, 16'hffff, 9'h0, 8'h0);
    send_fields(ACT_READ, 5'd0, 16'h0, 9'h1ff, 8'hff);
    send_fields(ACT_WRITE, REG_OWN_ID, 16'hffff, 9'h0, 8'h0);
    send_fields(ACT_READ, REG_OWN_ID, 16'h0, 9'h0, 8'h0);
    send_fields(ACT_WRITE, 5'd31, 16'hffff, 9'h0, 8'h0);
    send_fields(ACT_READ, 5'd31, 16'h0, 9'h0, 8'h0);
    send_fields(ACT_READ, REG_DSTAT, 16'h0, 9'h1ff, 8'h0);
    send_fields(ACT_WRITE, REG_COMM, CMD_SELECT, 9'h0, 8'h0);
    repeat (12) tick(9'h0, 8'h0);
    send_fields(ACT_CTRL, 0, 0, C_BSY, 8'h0);
    send_fields(ACT_CTRL, 0, 0, C_REQ | 9'h2, 8'h0);
    send_fields(ACT_WRITE, REG_CSTAT, 16'hffff, 9'h0, 8'h0);
    send_fields(ACT_WRITE, REG_COMM, CMD_DISCON | 16'h8, 9'h0, 8'h0);
    send_fields(ACT_CTRL, 0, 0, 9'h0, 8'h0);
    send_fields(ACT_CTRL, 0, 0, C_REQ | C_IO, 8'h0);
    send_fields(ACT_WRITE, REG_COMM, CMD_XFER | 16'h1, 9'h1, 8'h0);
    tick(C_REQ | C_IO, 8'h0);
    send_fields(ACT_WRITE, REG_COMM, CMD_XFER | 16'h8000, 9'h0, 8'h0);
    send_fields(ACT_CTRL, 0, 0, C_RST, 8'h0);
    send_fields(ACT_WRITE, REG_DSTAT, 16'hffff, 9'h0, 8'h0);
    send_fields(ACT_WRITE, REG_COMM, CMD_CHIP_RESET, 9'h0, 8'h0);
    send_fields(ACT_READ, REG_COMM, 0, 9'h0, 8'h0);

    // Phases: each timing setting is applied while the block is idle.
    sent = 0;
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_timing(CFG_ARB_WAIT, 12'd4095); write_timing(CFG_BUS_FREE, 12'd4095);
          write_timing(CFG_CLR_SET, 12'd4095); write_timing(CFG_SETTLE, 12'd4095);
          write_timing(CFG_SKEW_PAIR, 12'd4095);
        end
        default: begin
          write_timing(CFG_ARB_WAIT, 12'($urandom_range(0, 3)));
          write_timing(CFG_BUS_FREE, 12'($urandom_range(0, 3)));
          write_timing(CFG_CLR_SET, 12'($urandom_range(0, 3)));
          write_timing(CFG_SETTLE, 12'($urandom_range(0, 3)));
          write_timing(CFG_SKEW_PAIR, 12'($urandom_range(0, 3)));
        end
      endcase
      for (int n = 0; n < 340; ) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin selection_run(phase == 0 ? 6 : 16); n += 20; end
          4, 5, 6: begin pio_run(); n += 10; end
          default: begin random_item(); n++; end
        endcase
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sisq_pkg.sv
hw/rtl/sisq_if.sv
hw/rtl/sisq_core.sv
hw/rtl/scsi_initiator_select_sequencer.sv
verif/sisq_checker.sv
verif/tb.sv
